[rtl/sfpf_pkg.sv]
// Package for the SPI flash packet FIFO: payload structs, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sfpf_pkg;
  localparam int PacketBytes = 32;
  localparam int FlashBytes  = 16777216;
  localparam int PtrW = $clog2(FlashBytes);
  localparam int IdxW = $clog2(PacketBytes);
  localparam int CntW = $clog2(PacketBytes + 1);

  typedef enum logic [1:0] {
    FUNC_ERASE = 2'd0, FUNC_PUSH = 2'd1, FUNC_POP = 2'd2, FUNC_REPLY = 2'd3
  } func_t;
  typedef enum logic [1:0] {
    KIND_SPI = 2'd0, KIND_DATA = 2'd1, KIND_STATUS = 2'd2, KIND_RSVD = 2'd3
  } kind_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_PROG_FAIL = 2'd2, ST_ERASE_FAIL = 2'd3
  } status_t;

  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_WRDI = 8'h04;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_RDSCUR = 8'h2B;
  localparam logic [7:0] CMD_PP = 8'h02;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_CE = 8'h60;
  localparam logic [7:0] SR_WIP = 8'h01;
  localparam logic [7:0] SR_WEL = 8'h02;
  localparam logic [7:0] SCUR_PFAIL = 8'h20;
  localparam logic [7:0] SCUR_EFAIL = 8'h40;
  localparam logic [7:0] PAD_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] spi_byte;
    logic       end_of_frame;
    logic       expect_reply;
    logic [7:0] host_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;
endpackage
`default_nettype wire

[rtl/sfpf_out_reg.sv]
// Output register stage for the result channel.
// Depends on sfpf_pkg for the result struct.
`default_nettype none
module sfpf_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire sfpf_pkg::out_item_t load_item,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sfpf_pkg::out_item_t     out_item
);
  import sfpf_pkg::*;
  logic      valid_r;
  out_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign full      = valid_r && !out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;
endmodule
`default_nettype wire

[rtl/spi_flash_packet_fifo.sv]
// Top level of the SPI flash packet FIFO: transaction decode and byte sequencer.
// Depends on sfpf_pkg and sfpf_out_reg.
//
// Channel | Direction | Handshake
// in_     | input     | in_valid / in_ready, in_item
// out_    | output    | out_valid / out_ready, out_item
//
// One input transaction emits up to 38 results.
// The sequencer emits one result per cycle, while the output is not stalled, through a single output register.
// Reset is synchronous, active low, and clears pointers, counts and phase.
// A stalled output holds the sequencer; in_ready is low while results remain.
`default_nettype none
module spi_flash_packet_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sfpf_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sfpf_pkg::out_item_t     out_item
);
  import sfpf_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_WEL, PH_BUSY, PH_SCUR} phase_t;
  typedef enum logic [3:0] {
    SQ_NONE, SQ_WREN, SQ_POLL_CMD, SQ_POLL_DUMMY, SQ_PP_CMD, SQ_ADDR,
    SQ_PROG_DATA, SQ_CE, SQ_SCUR_CMD, SQ_SCUR_DUMMY, SQ_WRDI, SQ_STATUS,
    SQ_RD_CMD, SQ_RD_DUMMY, SQ_DATA
  } step_t;
  typedef enum logic [1:0] {OP_NONE, OP_PROGRAM, OP_READ, OP_ERASE} op_t;

  phase_t        phase_r;
  logic          reading_r;
  op_t           op_r;
  step_t         step_r;
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [CntW-1:0] fill_r, rcnt_r, cnt_r;
  logic [1:0]    acnt_r;
  logic [1:0]    stat_r;
  logic [7:0]    hbyte_r;
  logic [7:0]    buf_mem [PacketBytes];
  logic [7:0]    buf_rd_r;

  logic      emit, full;
  out_item_t res;
  logic [PtrW-1:0] addr;
  logic [7:0]      abyte;

  assign in_ready = (step_r == SQ_NONE);
  assign emit     = (step_r != SQ_NONE) && !full;
  assign addr     = (op_r == OP_PROGRAM) ? wptr_r : rptr_r;

  always_comb begin
    unique case (acnt_r)
      2'd0:    abyte = 8'(addr >> 16);
      2'd1:    abyte = 8'(addr >> 8);
      default: abyte = addr[7:0];
    endcase
  end

  always_comb begin
    res = '0;
    res.kind = KIND_SPI;
    unique case (step_r)
      SQ_WREN:       begin res.spi_byte = CMD_WREN; res.end_of_frame = 1'b1; end
      SQ_POLL_CMD:   res.spi_byte = CMD_RDSR;
      SQ_POLL_DUMMY: begin res.end_of_frame = 1'b1; res.expect_reply = 1'b1;
                           res.last = 1'b1; end
      SQ_PP_CMD:     res.spi_byte = CMD_PP;
      SQ_ADDR:       res.spi_byte = abyte;
      SQ_PROG_DATA:  begin res.spi_byte = buf_rd_r;
                           res.end_of_frame = (cnt_r == CntW'(PacketBytes - 1)); end
      SQ_CE:         begin res.spi_byte = CMD_CE; res.end_of_frame = 1'b1; end
      SQ_SCUR_CMD:   res.spi_byte = CMD_RDSCUR;
      SQ_SCUR_DUMMY: begin res.end_of_frame = 1'b1; res.expect_reply = 1'b1;
                           res.last = 1'b1; end
      SQ_WRDI:       begin res.spi_byte = CMD_WRDI; res.end_of_frame = 1'b1; end
      SQ_STATUS:     begin res.kind = KIND_STATUS; res.status = stat_r;
                           res.last = 1'b1; end
      SQ_RD_CMD:     res.spi_byte = CMD_READ;
      SQ_RD_DUMMY:   begin res.expect_reply = 1'b1;
                           res.end_of_frame = (cnt_r == CntW'(PacketBytes - 1));
                           res.last = res.end_of_frame; end
      SQ_DATA:       begin res.kind = KIND_DATA; res.host_byte = hbyte_r;
                           res.last = (stat_r == ST_EMPTY) ? 1'b1 : 1'b0; end
      default:       res = '0;
    endcase
  end

  logic acc;
  logic [7:0] d;
  logic prog_fail;
  assign acc = in_valid && in_ready;
  assign d   = in_item.data_byte;
  assign prog_fail = (op_r == OP_PROGRAM) ? ((d & SCUR_PFAIL) != 0)
                                          : ((d & SCUR_EFAIL) != 0);

  always_ff @(posedge clk) begin
    if (acc && in_item.func == FUNC_PUSH && phase_r == PH_IDLE && !reading_r
        && fill_r < CntW'(PacketBytes)) begin
      buf_mem[fill_r[IdxW-1:0]] <= d;
    end
    if (step_r == SQ_ADDR || step_r == SQ_PROG_DATA) begin
      if (step_r == SQ_ADDR || (emit && cnt_r != CntW'(PacketBytes - 1))) begin
        buf_rd_r <= (CntW'(step_r == SQ_ADDR ? '0 : cnt_r + 1'b1) < fill_r)
                    ? buf_mem[IdxW'(step_r == SQ_ADDR ? '0 : cnt_r + 1'b1)] : PAD_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; reading_r <= 1'b0; op_r <= OP_NONE; step_r <= SQ_NONE;
      wptr_r <= '0; rptr_r <= '0; fill_r <= '0; rcnt_r <= '0; cnt_r <= '0;
      acnt_r <= '0; stat_r <= ST_OK; hbyte_r <= '0;
    end else if (acc) begin
      cnt_r <= '0; acnt_r <= '0;
      if (phase_r == PH_IDLE && !reading_r) begin
        unique case (in_item.func)
          FUNC_ERASE: begin op_r <= OP_ERASE; step_r <= SQ_WREN; phase_r <= PH_WEL; end
          FUNC_PUSH: begin
            if (fill_r < CntW'(PacketBytes)) fill_r <= fill_r + 1'b1;
            if (in_item.last_byte || fill_r >= CntW'(PacketBytes - 1)) begin
              op_r <= OP_PROGRAM; step_r <= SQ_WREN; phase_r <= PH_WEL;
            end
          end
          FUNC_POP: begin
            if (rptr_r == wptr_r) begin
              stat_r <= ST_EMPTY; step_r <= SQ_STATUS;
            end else begin
              op_r <= OP_READ; step_r <= SQ_RD_CMD; reading_r <= 1'b1; rcnt_r <= '0;
            end
          end
          default: ;
        endcase
      end else if (in_item.func == FUNC_REPLY) begin
        if (reading_r) begin
          hbyte_r <= d; step_r <= SQ_DATA;
          rcnt_r <= (rcnt_r == CntW'(PacketBytes - 1)) ? '0 : rcnt_r + 1'b1;
          stat_r <= (rcnt_r == CntW'(PacketBytes - 1)) ? ST_PROG_FAIL : ST_EMPTY;
          if (rcnt_r == CntW'(PacketBytes - 1)) begin
            rptr_r <= PtrW'(rptr_r + PtrW'(PacketBytes));
            reading_r <= 1'b0; op_r <= OP_NONE;
          end
        end else begin
          unique case (phase_r)
            PH_WEL: begin
              if ((d & SR_WEL) != 0) begin
                step_r <= (op_r == OP_PROGRAM) ? SQ_PP_CMD : SQ_CE;
                phase_r <= PH_BUSY;
              end else begin
                step_r <= SQ_WREN;
              end
            end
            PH_BUSY: begin
              if ((d & SR_WIP) != 0) step_r <= SQ_POLL_CMD;
              else begin step_r <= SQ_SCUR_CMD; phase_r <= PH_SCUR; end
            end
            PH_SCUR: begin
              step_r <= SQ_WRDI;
              stat_r <= prog_fail ? ((op_r == OP_PROGRAM) ? ST_PROG_FAIL : ST_ERASE_FAIL)
                                  : ST_OK;
              if (op_r == OP_PROGRAM && !prog_fail)
                wptr_r <= PtrW'(wptr_r + PtrW'(PacketBytes));
              phase_r <= PH_IDLE; op_r <= OP_NONE;
            end
            default: phase_r <= PH_IDLE;
          endcase
        end
      end
    end else if (emit) begin
      unique case (step_r)
        SQ_WREN:     step_r <= SQ_POLL_CMD;
        SQ_POLL_CMD: step_r <= SQ_POLL_DUMMY;
        SQ_PP_CMD, SQ_RD_CMD: step_r <= SQ_ADDR;
        SQ_ADDR: begin
          acnt_r <= acnt_r + 1'b1;
          if (acnt_r == 2'd2)
            step_r <= (op_r == OP_PROGRAM) ? SQ_PROG_DATA : SQ_RD_DUMMY;
        end
        SQ_PROG_DATA: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(PacketBytes - 1)) begin
            step_r <= SQ_POLL_CMD; fill_r <= '0;
          end
        end
        SQ_RD_DUMMY: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(PacketBytes - 1)) step_r <= SQ_NONE;
        end
        SQ_CE:       step_r <= SQ_POLL_CMD;
        SQ_SCUR_CMD: step_r <= SQ_SCUR_DUMMY;
        SQ_WRDI:     step_r <= SQ_STATUS;
        SQ_DATA:     step_r <= (stat_r == ST_EMPTY) ? SQ_NONE : SQ_STATUS;
        default:     step_r <= SQ_NONE;
      endcase
      if (step_r == SQ_DATA && stat_r != ST_EMPTY) stat_r <= ST_OK;
    end
  end

  sfpf_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .load(emit), .load_item(res), .full(full),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for the SPI flash packet FIFO: a directed table, then random flash
// sessions, all checked against a behavioural predictor. Depends on sfpf_pkg.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfpf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  spi_flash_packet_fifo uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
  );

  typedef enum int {PH_IDLE, PH_WEL, PH_BUSY, PH_SCUR, PH_READ} phase_t;
  typedef enum int {OP_NONE, OP_PROGRAM, OP_READ, OP_ERASE} op_t;

  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [7:0] page_buf [PacketBytes];
  int fill, replies;
  phase_t phase;
  op_t pending;
  out_item_t flash_expected [$];
  int errors, checked, n_sent, idle_pct, cycles;
  bit hold_ok;

  task automatic emit(logic [1:0] k, logic [7:0] sb, bit eof, bit er,
                      logic [7:0] hb, logic [1:0] st);
    out_item_t r;
    r = '{kind: k, spi_byte: sb, end_of_frame: eof, expect_reply: er,
          host_byte: hb, status: st, last: 1'b0};
    flash_expected.push_back(r);
  endtask

  task automatic spi_out(logic [7:0] b, bit eof, bit er);
    emit(KIND_SPI, b, eof, er, 8'h00, ST_OK);
  endtask

  task automatic status_poll();
    spi_out(CMD_RDSR, 0, 0);
    spi_out(8'h00, 1, 1);
  endtask

  task automatic wren_poll();
    spi_out(CMD_WREN, 1, 0);
    status_poll();
  endtask

  task automatic send_address(logic [PtrW-1:0] a);
    spi_out(a[23:16], 0, 0);
    spi_out(a[15:8], 0, 0);
    spi_out(a[7:0], 0, 0);
  endtask

  task automatic predict_flash(in_item_t it);
    int n0;
    bit prog, fail;
    n0 = flash_expected.size();
    if (phase == PH_IDLE) begin
      if (it.func == FUNC_ERASE) begin
        pending = OP_ERASE;
        wren_poll();
        phase = PH_WEL;
      end else if (it.func == FUNC_PUSH) begin
        if (fill < PacketBytes) begin
          page_buf[fill] = it.data_byte;
          fill++;
        end
        if (it.last_byte || fill >= PacketBytes) begin
          while (fill < PacketBytes) begin
            page_buf[fill] = PAD_BYTE;
            fill++;
          end
          pending = OP_PROGRAM;
          wren_poll();
          phase = PH_WEL;
        end
      end else if (it.func == FUNC_POP) begin
        if (rd_ptr == wr_ptr) begin
          emit(KIND_STATUS, 0, 0, 0, 0, ST_EMPTY);
        end else begin
          spi_out(CMD_READ, 0, 0);
          send_address(rd_ptr);
          for (int i = 0; i < PacketBytes; i++) spi_out(8'h00, i == PacketBytes - 1, 1);
          pending = OP_READ;
          replies = 0;
          phase = PH_READ;
        end
      end
    end else if (it.func == FUNC_REPLY) begin
      case (phase)
        PH_WEL: begin
          if (it.data_byte & SR_WEL) begin
            if (pending == OP_PROGRAM) begin
              spi_out(CMD_PP, 0, 0);
              send_address(wr_ptr);
              for (int i = 0; i < PacketBytes; i++)
                spi_out(page_buf[i], i == PacketBytes - 1, 0);
              fill = 0;
            end else begin
              spi_out(CMD_CE, 1, 0);
            end
            status_poll();
            phase = PH_BUSY;
          end else begin
            wren_poll();
          end
        end
        PH_BUSY: begin
          if (it.data_byte & SR_WIP) begin
            status_poll();
          end else begin
            spi_out(CMD_RDSCUR, 0, 0);
            spi_out(8'h00, 1, 1);
            phase = PH_SCUR;
          end
        end
        PH_SCUR: begin
          prog = (pending == OP_PROGRAM);
          fail = prog ? |(it.data_byte & SCUR_PFAIL) : |(it.data_byte & SCUR_EFAIL);
          spi_out(CMD_WRDI, 1, 0);
          if (prog && !fail) wr_ptr = wr_ptr + PacketBytes;
          emit(KIND_STATUS, 0, 0, 0, 0, fail ? (prog ? ST_PROG_FAIL : ST_ERASE_FAIL) : ST_OK);
          phase = PH_IDLE;
          pending = OP_NONE;
        end
        PH_READ: begin
          emit(KIND_DATA, 0, 0, 0, it.data_byte, ST_OK);
          replies++;
          if (replies >= PacketBytes) begin
            rd_ptr = rd_ptr + PacketBytes;
            emit(KIND_STATUS, 0, 0, 0, 0, ST_OK);
            replies = 0;
            phase = PH_IDLE;
            pending = OP_NONE;
          end
        end
        default: begin
          phase = PH_IDLE;
          pending = OP_NONE;
        end
      endcase
    end
    if (flash_expected.size() > n0) flash_expected[$].last = 1'b1;
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycles, flash_expected.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      checked++;
      if (flash_expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %p", out_item);
      end else begin
        want = flash_expected.pop_front();
        if (out_item !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", want, out_item);
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready <= hold_ok || ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send(logic [1:0] f, logic [7:0] d, bit lb);
    in_item_t it;
    it = '{func: f, data_byte: d, last_byte: lb};
    while (!hold_ok && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_flash(it);
    n_sent++;
    @(negedge clk);
  endtask

  // Replies steering the current sequence: mostly a clean path, sometimes a retry or fault.
  function automatic logic [7:0] flash_reply();
    logic [7:0] r;
    r = $urandom_range(255);
    case (phase)
      PH_WEL:  if ($urandom_range(99) < 80) r = r | SR_WEL; else r = r & ~SR_WEL;
      PH_BUSY: if ($urandom_range(99) < 70) r = r & ~SR_WIP; else r = r | SR_WIP;
      PH_SCUR: if ($urandom_range(99) < 75) r = r & ~(SCUR_PFAIL | SCUR_EFAIL);
      default: ;
    endcase
    return r;
  endfunction

  task automatic finish_sequence();
    int guard;
    guard = 0;
    while (phase != PH_IDLE && guard < 200) begin
      if ($urandom_range(99) < 5) send($urandom_range(2), $urandom_range(255), $urandom_range(1));
      else send(FUNC_REPLY, flash_reply(), $urandom_range(1));
      guard++;
    end
  endtask

  typedef struct {
    logic [1:0] f;
    logic [7:0] d;
    bit lb;
    bit fixed;
    out_item_t want;
  } vector_t;

  vector_t vectors [$];

  initial begin
    int len;
    errors = 0; checked = 0; n_sent = 0; idle_pct = 24; hold_ok = 0;
    wr_ptr = '0; rd_ptr = '0; fill = 0; replies = 0;
    phase = PH_IDLE; pending = OP_NONE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    vectors = '{
      '{FUNC_POP, 8'h00, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 1'b0, 1'b0, 8'h00, ST_EMPTY, 1'b1}},
      '{FUNC_REPLY, 8'hFF, 1'b1, 1'b0, '0},
      '{FUNC_PUSH, 8'h00, 1'b0, 1'b0, '0},
      '{FUNC_PUSH, 8'hFF, 1'b1, 1'b0, '0},
      '{FUNC_PUSH, 8'h55, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h00, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'hFF, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h01, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'hFE, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h20, 1'b0, 1'b0, '0},
      '{FUNC_PUSH, 8'hAA, 1'b1, 1'b0, '0},
      '{FUNC_REPLY, 8'h02, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h00, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'hDF, 1'b0, 1'b0, '0},
      '{FUNC_ERASE, 8'h00, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h02, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h00, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h40, 1'b0, 1'b0, '0},
      '{FUNC_ERASE, 8'h00, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h02, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'h00, 1'b0, 1'b0, '0},
      '{FUNC_REPLY, 8'hBF, 1'b0, 1'b0, '0},
      '{FUNC_POP, 8'h00, 1'b0, 1'b0, '0}
    };
    foreach (vectors[i]) begin
      send(vectors[i].f, vectors[i].d, vectors[i].lb);
      if (vectors[i].fixed && flash_expected.size() > 0)
        flash_expected[$] = vectors[i].want;
    end
    finish_sequence();

    // Random sessions; one stretch runs with out_ready always high and no idle gaps on the input.
    while (n_sent < 125) begin
      hold_ok = (n_sent >= 60 && n_sent < 95);
      case ($urandom_range(9))
        0: send(FUNC_ERASE, $urandom_range(255), $urandom_range(1));
        1, 2: send(FUNC_POP, $urandom_range(255), $urandom_range(1));
        3: send(FUNC_REPLY, $urandom_range(255), $urandom_range(1));
        default: begin
          len = ($urandom_range(9) == 0) ? PacketBytes : $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            send(FUNC_PUSH, $urandom_range(255), i == len - 1);
        end
      endcase
      finish_sequence();
    end
    hold_ok = 0;

    // The sender holds off until the block has drained.
    in_valid <= 1'b0;
    while (flash_expected.size() > 0) @(posedge clk);
    send(FUNC_POP, 8'h00, 1'b0);
    finish_sequence();

    in_valid <= 1'b0;
    while (flash_expected.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d transactions (push, pop, erase, flash replies) and checked %0d results,",
             n_sent, checked);
    $display("covering WEL retries, busy polls, program and erase faults and empty pops.");
    if (errors == 0 && flash_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding.", errors, flash_expected.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
